FILE: rtl/hid_pkg.sv
// shared constants, types and state codes for the heartbeat interval detector
package hid_pkg;

  // sample and interval widths
  localparam int LEVEL_W      = 12;
  localparam int IVL_W        = 12;
  localparam int IVL_MAX      = 4095;
  localparam int TIME_W       = 32;

  // interval history
  localparam int HIST_DEPTH   = 10;
  localparam int HIST_AW      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SUM_W        = $clog2(HIST_DEPTH * IVL_MAX + 1);

  // mean interval as (sum * MEAN_MUL) >> MEAN_SHIFT, exact over the full sum range
  localparam int MEAN_SHIFT   = 19;
  localparam int MEAN_MUL     = ((2 ** MEAN_SHIFT) + HIST_DEPTH - 1) / HIST_DEPTH;
  localparam int MEAN_MW      = $clog2(MEAN_MUL + 1);

  // rate computation
  localparam int RATE_NUM     = 60000;
  localparam int RATE_MAX     = 200;
  localparam int RATE_MIN     = 30;
  localparam int RATE_W       = 8;
  localparam int NUM_W        = $clog2(RATE_NUM + 1);
  localparam int DIV_W        = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int DIV_CW       = $clog2(DIV_W);

  // 3/5 gate: x/5 as (x * 6554) >> 15, exact for twelve-bit x
  localparam int DIV5_MUL     = 6554;
  localparam int DIV5_MW      = 13;
  localparam int DIV5_SHIFT   = 15;
  localparam int Q5_W         = 10;

  // configuration port
  localparam int CFG_AW       = 2;
  localparam int CFG_DW       = 12;
  localparam int PERIOD_W     = 7;

  // register reset values
  localparam int PERIOD_RST   = 2;
  localparam int IDLE_RST     = 512;
  localparam int REFR_RST     = 250;
  localparam int TMO_RST      = 2500;
  localparam int IVL_RST      = 600;

  // stream widths
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 24;
  localparam int OUT_PAD_W    = OUT_TDATA_W - (RATE_W + 1 + LEVEL_W);

  typedef enum logic [CFG_AW-1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_IDLE_LEVEL    = 2'd1,
    CFG_REFRACTORY    = 2'd2,
    CFG_TIMEOUT       = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELAP,
    ST_DEC,
    ST_FILL,
    ST_RD,
    ST_SUM,
    ST_DIV_MEAN,
    ST_DIV_RATE,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/heartbeat_interval_detector.sv
// heartbeat interval detector: one result request per sample request
//
// Each sample request advances a millisecond clock, tracks peak and trough,
// keeps a midpoint threshold and flags beats. A sample without a new rate
// passes from the elapsed-time and decision states straight to the result.
// A beat that updates the rate goes through the history read and
// running-sum update, the mean interval by reciprocal multiplication, then
// the bit-serial divider for 60000/mean, which is skipped when the mean is
// zero; the beat after the seed beat instead writes every entry of the
// history memory with its interval first. The seed beat gives no rate.
// The interval history sits in a small memory with a running sum register,
// read and written once per beat after the fill. A new sample is taken
// while the last result is still waiting on the output register; the next
// result then waits until that register is free.
module heartbeat_interval_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hid_pkg::IN_TDATA_W-1:0] in_tdata,   // [11:0] sample
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] rate_bpm, [8] pulse_high, [20:9] threshold_level
  output logic [hid_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tuser,  // [0] beat_found
  input  logic                           cfg_we,
  input  logic [hid_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [hid_pkg::CFG_DW-1:0]     cfg_wdata
);
  import hid_pkg::*;

  state_t                state_r, state_nxt;

  logic [PERIOD_W-1:0]   period_r;
  logic [LEVEL_W-1:0]    idle_r;
  logic [CFG_DW-1:0]     refr_r;
  logic [CFG_DW-1:0]     tmo_r;

  logic [TIME_W-1:0]     time_now_r;
  logic [TIME_W-1:0]     last_beat_r;
  logic [TIME_W-1:0]     n_r;
  logic [IVL_W-1:0]      bi_r;
  logic [IVL_W-1:0]      gate_r;
  logic [LEVEL_W-1:0]    s_r;
  logic [LEVEL_W-1:0]    peak_r;
  logic [LEVEL_W-1:0]    trough_r;
  logic [LEVEL_W-1:0]    thr_r;
  logic                  in_pulse_r;
  logic                  first_r;
  logic                  second_r;
  logic                  fill_r;
  logic                  found_r;
  logic [RATE_W-1:0]     rate_r;

  logic [HIST_AW-1:0]    wp_r;
  logic [HIST_AW-1:0]    fill_cnt_r;
  logic [SUM_W-1:0]      sum_r;
  logic [IVL_W-1:0]      hist_mem [HIST_DEPTH];
  logic [IVL_W-1:0]      mem_rdata_r;
  logic                  mem_we;
  logic [HIST_AW-1:0]    mem_addr;

  logic [DIV_W-1:0]      div_rem_r;
  logic [DIV_W-1:0]      div_quo_r;
  logic [DIV_W-1:0]      div_den_r;
  logic [DIV_CW-1:0]     div_cnt_r;
  logic [DIV_W:0]        rem_sh;
  logic [DIV_W:0]        rem_step;
  logic [DIV_W-1:0]      quo_step;
  logic                  div_ge;
  logic                  div_last;

  logic                  out_valid_r;
  logic [RATE_W-1:0]     out_rate_r;
  logic                  out_found_r;
  logic                  out_pulse_r;
  logic [LEVEL_W-1:0]    out_thr_r;
  logic                  out_load;

  // decision terms
  logic                  lt_thr, gt_thr, past_gate, past_refr, past_tmo;
  logic                  beat, seed, fill_last;
  logic [IVL_W-1:0]      n_clamp;
  logic [LEVEL_W-1:0]    peak_upd, trough_upd, mid;
  logic signed [LEVEL_W:0] span, half;
  logic [LEVEL_W:0]      mid_sum;
  logic [IVL_W+DIV5_MW-1:0] q5_prod;
  logic [Q5_W-1:0]       q5;
  logic [SUM_W-1:0]      sum_fill, sum_shift;
  logic [SUM_W+MEAN_MW-1:0] mean_prod;
  logic [IVL_W-1:0]      mean;
  logic [RATE_W-1:0]     rate_clamp;

  assign lt_thr    = s_r < thr_r;
  assign gt_thr    = s_r > thr_r;
  assign past_gate = n_r > TIME_W'(gate_r);
  assign past_refr = n_r > TIME_W'(refr_r);
  assign past_tmo  = n_r > TIME_W'(tmo_r);
  assign beat      = past_refr && gt_thr && !in_pulse_r && past_gate;
  assign seed      = beat && first_r;
  assign n_clamp   = (n_r > TIME_W'(IVL_MAX)) ? IVL_W'(IVL_MAX) : n_r[IVL_W-1:0];

  assign peak_upd   = (gt_thr && s_r > peak_r) ? s_r : peak_r;
  assign trough_upd = (lt_thr && past_gate && s_r < trough_r) ? s_r : trough_r;
  // halve the signed span, rounding toward zero
  assign span    = $signed({1'b0, peak_upd}) - $signed({1'b0, trough_upd});
  assign half    = (span + $signed({{LEVEL_W{1'b0}}, span[LEVEL_W]})) >>> 1;
  assign mid_sum = $unsigned(half) + {1'b0, trough_upd};
  assign mid     = mid_sum[LEVEL_W-1:0];

  assign q5_prod = {{DIV5_MW{1'b0}}, bi_r} * (IVL_W+DIV5_MW)'(DIV5_MUL);
  assign q5      = q5_prod[DIV5_SHIFT +: Q5_W];

  assign sum_fill  = SUM_W'(SUM_W'(bi_r) * SUM_W'(HIST_DEPTH));
  assign sum_shift = sum_r - SUM_W'(mem_rdata_r) + SUM_W'(bi_r);
  assign fill_last = fill_cnt_r == HIST_AW'(HIST_DEPTH - 1);

  // mean interval by reciprocal multiplication
  assign mean_prod = {{MEAN_MW{1'b0}}, sum_r} * (SUM_W+MEAN_MW)'(MEAN_MUL);
  assign mean      = mean_prod[MEAN_SHIFT +: IVL_W];

  // restoring divider step
  assign rem_sh   = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_ge   = rem_sh >= {1'b0, div_den_r};
  assign rem_step = div_ge ? (rem_sh - {1'b0, div_den_r}) : rem_sh;
  assign quo_step = {div_quo_r[DIV_W-2:0], div_ge};
  assign div_last = div_cnt_r == DIV_CW'(DIV_W - 1);

  always_comb begin
    if (quo_step > DIV_W'(RATE_MAX)) begin
      rate_clamp = RATE_W'(RATE_MAX);
    end else if (quo_step < DIV_W'(RATE_MIN)) begin
      rate_clamp = RATE_W'(RATE_MIN);
    end else begin
      rate_clamp = quo_step[RATE_W-1:0];
    end
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = wp_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_ELAP;
      end
      ST_ELAP: state_nxt = ST_DEC;
      ST_DEC: begin
        if (beat && !first_r) begin
          state_nxt = second_r ? ST_FILL : ST_RD;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_FILL: begin
        mem_we   = 1'b1;
        mem_addr = fill_cnt_r;
        if (fill_last) state_nxt = ST_DIV_MEAN;
      end
      ST_RD: state_nxt = ST_SUM;
      ST_SUM: begin
        mem_we    = 1'b1;
        state_nxt = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        state_nxt = (mean == '0) ? ST_EMIT : ST_DIV_RATE;
      end
      ST_DIV_RATE: begin
        if (div_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_W'(PERIOD_RST);
      idle_r   <= LEVEL_W'(IDLE_RST);
      refr_r   <= CFG_DW'(REFR_RST);
      tmo_r    <= CFG_DW'(TMO_RST);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_SAMPLE_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        CFG_IDLE_LEVEL:    idle_r   <= cfg_wdata[LEVEL_W-1:0];
        CFG_REFRACTORY:    refr_r   <= cfg_wdata;
        CFG_TIMEOUT:       tmo_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r  <= '0;
      last_beat_r <= '0;
      bi_r        <= IVL_W'(IVL_RST);
      peak_r      <= LEVEL_W'(IDLE_RST);
      trough_r    <= LEVEL_W'(IDLE_RST);
      thr_r       <= LEVEL_W'(IDLE_RST);
      in_pulse_r  <= 1'b0;
      first_r     <= 1'b1;
      second_r    <= 1'b0;
      fill_r      <= 1'b0;
      found_r     <= 1'b0;
      rate_r      <= '0;
      wp_r        <= '0;
      fill_cnt_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) time_now_r <= time_now_r + TIME_W'(period_r);
        end
        ST_DEC: begin
          peak_r   <= peak_upd;
          trough_r <= trough_upd;
          found_r  <= 1'b0;
          fill_r   <= 1'b0;
          if (beat) begin
            in_pulse_r  <= 1'b1;
            bi_r        <= n_clamp;
            last_beat_r <= time_now_r;
            if (second_r) begin
              second_r <= 1'b0;
              fill_r   <= 1'b1;
            end
            if (first_r) begin
              first_r  <= 1'b0;
              second_r <= 1'b1;
            end
          end
          // pulse end and timeout are skipped on the seed beat
          if (!seed) begin
            if (lt_thr && in_pulse_r) begin
              in_pulse_r <= 1'b0;
              thr_r      <= mid;
              peak_r     <= mid;
              trough_r   <= mid;
            end
            if (past_tmo) begin
              peak_r      <= idle_r;
              trough_r    <= idle_r;
              thr_r       <= idle_r;
              last_beat_r <= time_now_r;
              first_r     <= 1'b1;
              second_r    <= 1'b0;
            end
          end
        end
        ST_FILL: begin
          fill_cnt_r <= fill_last ? '0 : fill_cnt_r + 1'b1;
        end
        ST_SUM: begin
          wp_r <= (wp_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        end
        ST_DIV_MEAN: begin
          if (mean == '0) begin
            rate_r  <= RATE_W'(RATE_MAX);
            found_r <= 1'b1;
          end
        end
        ST_DIV_RATE: begin
          if (div_last) begin
            rate_r  <= rate_clamp;
            found_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // sample, elapsed time, gate and running sum
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) s_r <= in_tdata[LEVEL_W-1:0];
    if (state_r == ST_ELAP) n_r <= time_now_r - last_beat_r;
    gate_r <= {2'b00, q5} + {1'b0, q5, 1'b0};
    if (state_r == ST_FILL && fill_last) sum_r <= sum_fill;
    if (state_r == ST_SUM) sum_r <= sum_shift;
  end

  // interval history memory
  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_addr] <= bi_r;
  end

  always_ff @(posedge clk) begin
    mem_rdata_r <= hist_mem[wp_r];
  end

  // rate divider: loaded with 60000 and the mean, one quotient bit per cycle
  always_ff @(posedge clk) begin
    case (state_r)
      ST_DIV_MEAN: begin
        div_quo_r <= DIV_W'(RATE_NUM);
        div_den_r <= DIV_W'(mean);
        div_rem_r <= '0;
        div_cnt_r <= '0;
      end
      ST_DIV_RATE: begin
        div_quo_r <= quo_step;
        div_rem_r <= rem_step[DIV_W-1:0];
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rate_r  <= rate_r;
      out_found_r <= found_r;
      out_pulse_r <= in_pulse_r;
      out_thr_r   <= thr_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_thr_r, out_pulse_r, out_rate_r};
  assign out_tuser  = out_found_r;

`ifndef NO_ASSERTIONS
  a_seed_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(first_r && second_r))
    else $error("seed and second beat pending together");

  a_level_order: assert property (@(posedge clk) disable iff (!rst_n)
    (trough_r <= thr_r) && (thr_r <= peak_r))
    else $error("threshold outside trough and peak");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_RATE) |-> (div_rem_r < div_den_r))
    else $error("divider remainder not below divisor");

  a_fill_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> fill_r)
    else $error("history fill without second beat");
`endif

endmodule

FILE: verif/heartbeat_rate_checker.sv
// checker for the heartbeat detector: predicts each reading and compares it with the output stream
module heartbeat_rate_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [hid_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [hid_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic [hid_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [hid_pkg::CFG_DW-1:0]      cfg_wdata,
  output int                              mismatches,
  output int                              readings_due,
  output int                              rate_updates
);
  import hid_pkg::*;

  typedef struct packed {
    logic [RATE_W-1:0]  rate_bpm;
    logic               beat_found;
    logic               pulse_high;
    logic [LEVEL_W-1:0] threshold_level;
  } reading_t;

  // register copies
  logic [PERIOD_W-1:0] period_ms;
  logic [LEVEL_W-1:0]  idle_lvl;
  logic [CFG_DW-1:0]   refr_ms;
  logic [CFG_DW-1:0]   tmo_ms;

  // detector state
  logic [TIME_W-1:0]  now_ms;
  logic [TIME_W-1:0]  last_beat_ms;
  logic [IVL_W-1:0]   ivl_ms;
  logic [IVL_W-1:0]   ivl_hist [HIST_DEPTH];
  logic [LEVEL_W-1:0] peak;
  logic [LEVEL_W-1:0] trough;
  logic [LEVEL_W-1:0] thr;
  logic               in_beat;
  logic               seed_armed;
  logic               fill_armed;
  logic [RATE_W-1:0]  bpm_now;

  reading_t expected_readings [$];
  int miss_n = 0;
  int beat_n = 0;

  assign mismatches   = miss_n;
  assign rate_updates = beat_n;

  task automatic clear_detector();
    period_ms    = PERIOD_W'(PERIOD_RST);
    idle_lvl     = LEVEL_W'(IDLE_RST);
    refr_ms      = CFG_DW'(REFR_RST);
    tmo_ms       = CFG_DW'(TMO_RST);
    now_ms       = '0;
    last_beat_ms = '0;
    ivl_ms       = IVL_W'(IVL_RST);
    foreach (ivl_hist[k]) ivl_hist[k] = '0;
    peak         = idle_lvl;
    trough       = idle_lvl;
    thr          = idle_lvl;
    in_beat      = 1'b0;
    seed_armed   = 1'b1;
    fill_armed   = 1'b0;
    bpm_now      = '0;
  endtask

  task automatic advance_detector(input logic [LEVEL_W-1:0] s, output reading_t r);
    logic [TIME_W-1:0] n;
    int unsigned gate;
    int unsigned sum;
    int unsigned mean;
    int unsigned bpm;
    int pk;
    int tr;
    logic found;
    logic seeded;
    found  = 1'b0;
    seeded = 1'b0;
    now_ms = now_ms + TIME_W'(period_ms);
    n      = now_ms - last_beat_ms;
    gate   = (ivl_ms / 5) * 3;

    if (s < thr && n > gate && s < trough) trough = s;
    if (s > thr && s > peak) peak = s;

    if (n > refr_ms && s > thr && !in_beat && n > gate) begin
      in_beat      = 1'b1;
      ivl_ms       = (n > IVL_MAX) ? IVL_W'(IVL_MAX) : n[IVL_W-1:0];
      last_beat_ms = now_ms;
      if (fill_armed) begin
        fill_armed = 1'b0;
        foreach (ivl_hist[k]) ivl_hist[k] = ivl_ms;
      end
      if (seed_armed) begin
        // seed beat marks the time and starts the pulse, no rate and no end-of-pulse or timeout checks
        seed_armed = 1'b0;
        fill_armed = 1'b1;
        seeded     = 1'b1;
      end else begin
        sum = 0;
        for (int k = 0; k < HIST_DEPTH - 1; k++) begin
          ivl_hist[k] = ivl_hist[k+1];
          sum += ivl_hist[k];
        end
        ivl_hist[HIST_DEPTH-1] = ivl_ms;
        sum += ivl_ms;
        mean = sum / HIST_DEPTH;
        bpm  = (mean == 0) ? RATE_MAX : RATE_NUM / mean;
        if (bpm > RATE_MAX) bpm = RATE_MAX;
        if (bpm < RATE_MIN) bpm = RATE_MIN;
        bpm_now = RATE_W'(bpm);
        found   = 1'b1;
      end
    end

    if (!seeded) begin
      if (s < thr && in_beat) begin
        pk      = int'(peak);
        tr      = int'(trough);
        in_beat = 1'b0;
        thr     = LEVEL_W'((pk - tr) / 2 + tr);
        peak    = thr;
        trough  = thr;
      end
      if (n > tmo_ms) begin
        peak         = idle_lvl;
        trough       = idle_lvl;
        thr          = idle_lvl;
        last_beat_ms = now_ms;
        seed_armed   = 1'b1;
        fill_armed   = 1'b0;
      end
    end

    r = '{bpm_now, found, in_beat, thr};
  endtask

  task automatic note_mismatch(input string why, input reading_t want, input reading_t got);
    miss_n++;
    if (miss_n <= 10)
      $display("mismatch %0d (%s): exp rate=%0d beat=%0b pulse=%0b thr=%0d, got rate=%0d beat=%0b pulse=%0b thr=%0d",
               miss_n, why, want.rate_bpm, want.beat_found, want.pulse_high,
               want.threshold_level, got.rate_bpm, got.beat_found, got.pulse_high,
               got.threshold_level);
  endtask

  always @(posedge clk) begin
    reading_t want;
    reading_t got;
    if (!rst_n) begin
      clear_detector();
      expected_readings.delete();
      readings_due <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SAMPLE_PERIOD: period_ms = cfg_wdata[PERIOD_W-1:0];
          CFG_IDLE_LEVEL:    idle_lvl  = cfg_wdata[LEVEL_W-1:0];
          CFG_REFRACTORY:    refr_ms   = cfg_wdata;
          CFG_TIMEOUT:       tmo_ms    = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[RATE_W-1:0], out_tuser, out_tdata[RATE_W],
                out_tdata[RATE_W+1 +: LEVEL_W]};
        if (got.beat_found) beat_n++;
        if (expected_readings.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_readings.pop_front();
          if (want !== got) note_mismatch("wrong field", want, got);
        end
      end
      if (in_tvalid && in_tready) begin
        advance_detector(in_tdata[LEVEL_W-1:0], want);
        expected_readings.push_back(want);
      end
      readings_due <= expected_readings.size();
    end
  end

endmodule

FILE: verif/heartbeat_interval_detector_tb.sv
// top of the heartbeat detector testbench: clock, reset, sample stimulus and verdict
module heartbeat_interval_detector_tb;
  import hid_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 60;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr   = '0;
  logic [CFG_DW-1:0]      cfg_wdata  = '0;

  int mismatches;
  int readings_due;
  int rate_updates;
  int send_idle_pct = 9;
  int take_idle_pct = 71;
  int hold_asked    = 0;
  int hold_given    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int samples_sent  = 0;
  int settings_used = 0;

  // opening samples: seed beat, pulse end, full-history beat, then a timeout
  int unsigned opening [21] = '{0, 0, 0, 0, 4095, 0, 1000, 1000, 1000, 3000, 0,
                                100, 100, 100, 100, 100, 100, 100, 100, 100, 100};

  heartbeat_interval_detector i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  heartbeat_rate_checker i_rate_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .readings_due (readings_due),
    .rate_updates (rate_updates)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, plus a long hold whenever one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_given != hold_asked) begin
      out_tready <= 1'b0;
      hold_given <= hold_given + 1;
      hold_left  <= LONG_HOLD;
    end else begin
      out_tready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer_sample(input int unsigned s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(s);
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (readings_due != 0);
  endtask

  task automatic put_register(input cfg_idx_t idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DW'(value);
    @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned period, input int unsigned idle,
                               input int unsigned refr, input int unsigned tmo);
    wait_drained();
    put_register(CFG_SAMPLE_PERIOD, period);
    put_register(CFG_IDLE_LEVEL, idle);
    put_register(CFG_REFRACTORY, refr);
    put_register(CFG_TIMEOUT, tmo);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // pulse-like waveform: crest of a few samples, then a noisy baseline gap;
  // some beats are replaced by full-range noise
  task automatic play_heartbeat(input int items, input int gap_lo, input int gap_hi);
    int left;
    int base;
    int crest;
    int gap;
    int width;
    bit noisy;
    int unsigned s;
    left = items;
    while (left > 0) begin
      base  = $urandom_range(1500);
      crest = $urandom_range(4095, base + 400);
      gap   = $urandom_range(gap_hi, gap_lo);
      width = $urandom_range(4, 1);
      noisy = ($urandom_range(99) < 15);
      for (int k = 0; k < width + gap && left > 0; k++) begin
        if (noisy)          s = $urandom_range(4095);
        else if (k < width) s = crest - $urandom_range(30);
        else                s = base + $urandom_range(40);
        offer_sample(s);
        left--;
      end
    end
  endtask

  task automatic run_phase(input int unsigned period, input int unsigned idle,
                           input int unsigned refr, input int unsigned tmo,
                           input int items, input int gap_lo, input int gap_hi);
    apply_setting(period, idle, refr, tmo);
    play_heartbeat(items, gap_lo, gap_hi);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    apply_setting(100, 2048, 0, 900);
    foreach (opening[k]) offer_sample(opening[k]);

    // sender mostly busy, receiver mostly stalling
    run_phase(20, 0, 250, 2500, 150, 25, 50);
    run_phase(10, 4095, 0, 3000, 200, 8, 20);

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 71;
    take_idle_pct = 9;
    run_phase(100, 2048, 3000, 4095, 200, 30, 42);
    run_phase(0, 1000, 100, 1, 30, 2, 6);
    run_phase(127, 300, 4095, 0, 40, 1, 10);

    // back to back, with a long output hold and a full drain in the middle
    send_idle_pct = 0;
    take_idle_pct = 0;
    apply_setting(1, 4095, 20, 3000);
    hold_asked++;
    play_heartbeat(75, 25, 60);
    wait_drained();
    play_heartbeat(75, 25, 60);
    run_phase(50, 0, 400, 2000, 170, 14, 40);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d samples under %0d register settings, %0d rate updates seen",
             samples_sent, settings_used, rate_updates);
    $display("incl. zero and maximum sample period, timeouts, long output hold and drain pause");
    if (mismatches == 0 && readings_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
